// File: src/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 3;
  localparam int CAP_W         = 11;
  localparam int TOTAL_W       = 11;
  localparam int CMDQ_DEPTH    = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(1024);
  localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH_FRONT,
    CMD_PUSH_REAR,
    CMD_POP_FRONT,
    CMD_POP_REAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef enum logic {
    BK_EXEC,
    BK_FETCH
  } back_state_t;

endpackage
`default_nettype wire

// File: src/bdq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/bdq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_front
// Input side: accepts items, decodes the opcode and queues commands.
// ----------------------------------------------------------------------------
module bdq_front
  import bdq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          opcode,
  input  wire logic signed [DATA_W-1:0] push_value,
  output logic                          cmd_valid,
  output cmd_t                          cmd,
  input  wire logic                     cmd_take
);

  localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int FW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           entries [CMDQ_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [FW-1:0]  fill;
  logic           push;
  logic           pop;
  cmd_t           decoded;

  always_comb begin
    decoded.value = push_value;
    unique case (opcode)
      OP_PUSH_FRONT: decoded.kind = CMD_PUSH_FRONT;
      OP_PUSH_REAR:  decoded.kind = CMD_PUSH_REAR;
      OP_POP_FRONT:  decoded.kind = CMD_POP_FRONT;
      OP_POP_REAR:   decoded.kind = CMD_POP_REAR;
      default:       decoded.kind = CMD_NONE;
    endcase
  end

  assign in_stall  = (fill == FW'(CMDQ_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = entries[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: src/bdq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_back
// Execution side: ring indices, count, end-value cache, slot store access
// and the result register.
// ----------------------------------------------------------------------------
module bdq_back
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cmd_valid,
  input  wire cmd_t                               cmd,
  output logic                                    cmd_take,
  input  wire logic [$clog2(DEPTH + 1)-1:0]       eff_cap,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    op_ok,
  output logic signed [DATA_W-1:0]                front_value,
  output logic signed [DATA_W-1:0]                rear_value,
  output logic                                    empty_flag,
  output logic                                    full_flag,
  output logic [TOTAL_W-1:0]                      entry_total
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  back_state_t        state;
  back_state_t        state_next;
  logic [IW-1:0]      front_idx;
  logic [IW-1:0]      rear_idx;
  logic [CW-1:0]      count;
  logic [DATA_W-1:0]  front_val;
  logic [DATA_W-1:0]  rear_val;
  logic               fetch_front;

  logic [IW-1:0]      front_idx_next;
  logic [IW-1:0]      rear_idx_next;
  logic [CW-1:0]      count_next;
  logic [DATA_W-1:0]  front_val_next;
  logic [DATA_W-1:0]  rear_val_next;
  logic               ok;
  logic               need_fetch;
  logic               fetch_front_next;
  logic               was_empty;
  logic               was_full;
  logic               now_empty;
  logic               out_free;
  logic               start;
  logic               fetch_done;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [IW-1:0]      ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? IW'(DEPTH - 1) : i - IW'(1);
  endfunction

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid || !out_stall;
  assign was_empty = (count == '0);
  assign was_full  = (count >= eff_cap);
  assign now_empty = (count_next == '0);

  always_comb begin
    front_idx_next   = front_idx;
    rear_idx_next    = rear_idx;
    count_next       = count;
    front_val_next   = front_val;
    rear_val_next    = rear_val;
    ok               = 1'b1;
    need_fetch       = 1'b0;
    fetch_front_next = 1'b1;
    ram_we           = 1'b0;
    ram_waddr        = front_idx;
    ram_raddr        = front_idx;
    unique case (cmd.kind)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        priority if (was_full) begin
          ok = 1'b0;
        end else if (was_empty) begin
          ram_we         = start;
          rear_idx_next  = front_idx;
          count_next     = CW'(1);
          front_val_next = cmd.value;
          rear_val_next  = cmd.value;
        end else if (cmd.kind == CMD_PUSH_FRONT) begin
          front_idx_next = idx_dec(front_idx);
          ram_we         = start;
          ram_waddr      = front_idx_next;
          count_next     = count + CW'(1);
          front_val_next = cmd.value;
        end else begin
          rear_idx_next = idx_inc(rear_idx);
          ram_we        = start;
          ram_waddr     = rear_idx_next;
          count_next    = count + CW'(1);
          rear_val_next = cmd.value;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        priority if (was_empty) begin
          ok = 1'b0;
        end else if (count == CW'(1)) begin
          count_next = '0;
        end else if (cmd.kind == CMD_POP_FRONT) begin
          front_idx_next = idx_inc(front_idx);
          count_next     = count - CW'(1);
          ram_raddr      = front_idx_next;
          if (count == CW'(2)) begin
            front_val_next = rear_val;
          end else begin
            need_fetch = 1'b1;
          end
        end else begin
          rear_idx_next    = idx_dec(rear_idx);
          count_next       = count - CW'(1);
          ram_raddr        = rear_idx_next;
          fetch_front_next = 1'b0;
          if (count == CW'(2)) begin
            rear_val_next = front_val;
          end else begin
            need_fetch = 1'b1;
          end
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      BK_EXEC:  state_next = (start && need_fetch) ? BK_FETCH : BK_EXEC;
      BK_FETCH: state_next = BK_EXEC;
    endcase
  end

  always_comb begin
    unique case (state)
      BK_EXEC: begin
        start      = cmd_valid && out_free;
        fetch_done = 1'b0;
      end
      BK_FETCH: begin
        start      = 1'b0;
        fetch_done = 1'b1;
      end
    endcase
  end

  assign cmd_take = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_EXEC;
      front_idx <= '0;
      rear_idx  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        front_idx <= front_idx_next;
        rear_idx  <= rear_idx_next;
        count     <= count_next;
      end
      priority if (start) begin
        out_valid <= !need_fetch;
      end else if (fetch_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      front_val   <= front_val_next;
      rear_val    <= rear_val_next;
      fetch_front <= fetch_front_next;
      op_ok       <= ok;
      front_value <= now_empty ? EMPTY_VALUE : front_val_next;
      rear_value  <= now_empty ? EMPTY_VALUE : rear_val_next;
      empty_flag  <= now_empty;
      full_flag   <= (count_next >= eff_cap);
      entry_total <= TOTAL_W'(count_next);
    end else if (fetch_done) begin
      if (fetch_front) begin
        front_val   <= ram_rdata;
        front_value <= ram_rdata;
      end else begin
        rear_val   <= ram_rdata;
        rear_value <= ram_rdata;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/bounded_double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded double-ended queue on a ring buffer with programmable capacity.
// Path: input transfer -> command queue -> result register; a pop that must
//   fetch the new end entry from the slot RAM also waits on its registered read.
// Throughput: 1 item per cycle unless out_stall holds the result or a
//   fetching pop holds the execution side for its registered RAM read.
// Reset (rst, synchronous): queue empty, indices zero, capacity 1024.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CAP_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [OP_W-1:0]          opcode,
  input  wire logic signed [DATA_W-1:0] push_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          op_ok,
  output logic signed [DATA_W-1:0]      front_value,
  output logic signed [DATA_W-1:0]      rear_value,
  output logic                          empty_flag,
  output logic                          full_flag,
  output logic [TOTAL_W-1:0]            entry_total
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] queue_capacity;
  logic [CW-1:0]    eff_cap;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_capacity <= CAP_RESET;
    end else if (cfg_write) begin
      queue_capacity <= cfg_data;
    end
  end

  // saturate capacity into 1..DEPTH
  always_comb begin
    priority if (queue_capacity == '0) begin
      eff_cap = CW'(1);
    end else if (32'(queue_capacity) > 32'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(queue_capacity);
    end
  end

  bdq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .push_value (push_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .eff_cap     (eff_cap),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .op_ok       (op_ok),
    .front_value (front_value),
    .rear_value  (rear_value),
    .empty_flag  (empty_flag),
    .full_flag   (full_flag),
    .entry_total (entry_total)
  );

endmodule
`default_nettype wire
